/* rtl/core/hsvrgb_pkg.sv */
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// shared types and constants of the rainbow hsv to rgb core
// ----------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

   // configuration port
   localparam int unsigned PADDR_W = 4;
   localparam int unsigned PDATA_W = 32;

   typedef enum logic [1:0] {
      CSR_YELLOW_STRONG = 2'd0,
      CSR_GREEN_HALVE   = 2'd1,
      CSR_GREEN_GAIN    = 2'd2
   } csr_index_type;

   // the eight sections of the rainbow wheel, hue bits 7..5
   typedef enum logic [2:0] {
      SEC_RED_ORANGE    = 3'd0,
      SEC_ORANGE_YELLOW = 3'd1,
      SEC_YELLOW_GREEN  = 3'd2,
      SEC_GREEN_AQUA    = 3'd3,
      SEC_AQUA_BLUE     = 3'd4,
      SEC_BLUE_PURPLE   = 3'd5,
      SEC_PURPLE_PINK   = 3'd6,
      SEC_PINK_RED      = 3'd7
   } section_type;

   // ramp scale factors, scale8 uses s + 1
   localparam logic [7:0] THIRD_MUL = 8'd86;   // (256 / 3) + 1
   localparam logic [7:0] TWO_MUL   = 8'd171;  // ((256 * 2) / 3) + 1

   // channel levels of the wheel
   localparam logic [7:0] LVL_FULL = 8'd255;
   localparam logic [7:0] LVL_171  = 8'd171;
   localparam logic [7:0] LVL_170  = 8'd170;
   localparam logic [7:0] LVL_85   = 8'd85;

   typedef struct packed {
      logic       yellow_strong;
      logic       green_halve;
      logic [7:0] green_gain;
   } cfg_type;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] sat;
      logic [7:0] val;
   } hsv_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // wheel colour plus the shading terms handed to the shade pipeline
   typedef struct packed {
      rgb_type    rgb;
      logic [7:0] desat;
      logic [7:0] vsq;
      logic       sat_zero;
      logic       sat_full;
      logic       val_full;
   } mix_type;

endpackage : hsvrgb_pkg

`default_nettype wire

/* rtl/core/hsvrgb_csr.sv */
// ----------------------------------------------------------------------------
// hsvrgb_csr
// apb register file: yellow strength, green halving and green gain
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [hsvrgb_pkg::PADDR_W-1:0] paddr,
   input  wire logic [hsvrgb_pkg::PDATA_W-1:0] pwdata,
   output logic      [hsvrgb_pkg::PDATA_W-1:0] prdata,
   output logic                               pready,
   output hsvrgb_pkg::cfg_type                cfg
);
   import hsvrgb_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type idx;
   logic          wr_en;

   assign idx    = csr_index_type'(paddr[3:2]);
   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            CSR_YELLOW_STRONG: cfg_in.yellow_strong = pwdata[0];
            CSR_GREEN_HALVE:   cfg_in.green_halve   = pwdata[0];
            CSR_GREEN_GAIN:    cfg_in.green_gain    = pwdata[7:0];
            default:           cfg_in = cfg_ff;  // unmapped, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         CSR_YELLOW_STRONG: prdata = PDATA_W'(cfg_ff.yellow_strong);
         CSR_GREEN_HALVE:   prdata = PDATA_W'(cfg_ff.green_halve);
         CSR_GREEN_GAIN:    prdata = PDATA_W'(cfg_ff.green_gain);
         default:           prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule : hsvrgb_csr

`default_nettype wire

/* rtl/core/hsvrgb_wheel.sv */
// ----------------------------------------------------------------------------
// hsvrgb_wheel
// three stages: ramps and squares, section mix, green adjustment
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_wheel (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire hsvrgb_pkg::cfg_type cfg,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire hsvrgb_pkg::hsv_type in_data,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output hsvrgb_pkg::mix_type      out_data
);
   import hsvrgb_pkg::*;

   typedef struct packed {
      section_type sec;
      logic [7:0]  pos;
      logic [7:0]  third;
      logic [7:0]  two;
      logic [7:0]  desat;
      logic [7:0]  vsq;
      logic        sat_zero;
      logic        sat_full;
      logic        val_full;
   } ramp_type;

   // stage 1: ramp position, thirds, squared desaturation and value
   logic       vld1_ff;
   ramp_type   s1_ff, s1_in;
   logic       ld1;
   logic [7:0] dsat;
   logic [15:0] p_third, p_two, p_desat, p_vsq;

   // stage 2: section mix
   logic       vld2_ff;
   mix_type    s2_ff, s2_in;
   logic       ld2;

   // stage 3: green gain
   logic       vld3_ff;
   mix_type    s3_ff, s3_in;
   logic       ld3;
   logic [15:0] p_gain;

   assign ld3      = ~vld3_ff | out_ready;
   assign ld2      = ~vld2_ff | ld3;
   assign ld1      = ~vld1_ff | ld2;
   assign in_ready = ld1;

   always_comb begin
      s1_in.pos      = {in_data.hue[4:0], 3'b000};
      dsat           = ~in_data.sat;
      p_third        = 16'(s1_in.pos) * 16'(THIRD_MUL);
      p_two          = 16'(s1_in.pos) * 16'(TWO_MUL);
      p_desat        = 16'(dsat) * 16'(dsat);
      p_vsq          = 16'(in_data.val) * 16'(in_data.val);
      s1_in.sec      = section_type'(in_data.hue[7:5]);
      s1_in.third    = p_third[15:8];
      s1_in.two      = p_two[15:8];
      // video scaling adds one for nonzero operands, never wraps here
      s1_in.desat    = p_desat[15:8] + 8'(dsat != 8'd0);
      s1_in.vsq      = p_vsq[15:8] + 8'(in_data.val != 8'd0);
      s1_in.sat_zero = (in_data.sat == 8'd0);
      s1_in.sat_full = (in_data.sat == LVL_FULL);
      s1_in.val_full = (in_data.val == LVL_FULL);
   end

   always_comb begin
      s2_in          = '0;
      s2_in.desat    = s1_ff.desat;
      s2_in.vsq      = s1_ff.vsq;
      s2_in.sat_zero = s1_ff.sat_zero;
      s2_in.sat_full = s1_ff.sat_full;
      s2_in.val_full = s1_ff.val_full;
      case (s1_ff.sec)
         SEC_RED_ORANGE: begin
            s2_in.rgb.red   = LVL_FULL - s1_ff.third;
            s2_in.rgb.green = s1_ff.third;
         end
         SEC_ORANGE_YELLOW: begin
            if (cfg.yellow_strong) begin
               s2_in.rgb.red   = LVL_170 + s1_ff.third;
               s2_in.rgb.green = LVL_85 + s1_ff.two;
            end else begin
               s2_in.rgb.red   = LVL_171;
               s2_in.rgb.green = LVL_85 + s1_ff.third;
            end
         end
         SEC_YELLOW_GREEN: begin
            if (cfg.yellow_strong) begin
               s2_in.rgb.red   = LVL_FULL - s1_ff.pos;
               s2_in.rgb.green = LVL_FULL;
            end else begin
               s2_in.rgb.red   = LVL_171 - s1_ff.two;
               s2_in.rgb.green = LVL_170 + s1_ff.third;
            end
         end
         SEC_GREEN_AQUA: begin
            s2_in.rgb.green = LVL_FULL - s1_ff.third;
            s2_in.rgb.blue  = s1_ff.third;
         end
         SEC_AQUA_BLUE: begin
            s2_in.rgb.green = LVL_171 - s1_ff.two;
            s2_in.rgb.blue  = LVL_85 + s1_ff.two;
         end
         SEC_BLUE_PURPLE: begin
            s2_in.rgb.red   = s1_ff.third;
            s2_in.rgb.blue  = LVL_FULL - s1_ff.third;
         end
         SEC_PURPLE_PINK: begin
            s2_in.rgb.red   = LVL_85 + s1_ff.third;
            s2_in.rgb.blue  = LVL_171 - s1_ff.third;
         end
         SEC_PINK_RED: begin
            s2_in.rgb.red   = LVL_170 + s1_ff.third;
            s2_in.rgb.blue  = LVL_85 - s1_ff.third;
         end
         default: s2_in.rgb = '0;
      endcase
      if (cfg.green_halve) begin
         s2_in.rgb.green = {1'b0, s2_in.rgb.green[7:1]};
      end
   end

   always_comb begin
      s3_in  = s2_ff;
      p_gain = 16'(s2_ff.rgb.green) * 16'(cfg.green_gain);
      if (cfg.green_gain != 8'd0) begin
         s3_in.rgb.green = p_gain[15:8] + 8'(s2_ff.rgb.green != 8'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else begin
         if (ld1) vld1_ff <= in_valid;
         if (ld2) vld2_ff <= vld1_ff;
         if (ld3) vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld1) s1_ff <= s1_in;
      if (ld2) s2_ff <= s2_in;
      if (ld3) s3_ff <= s3_in;
   end

   assign out_valid = vld3_ff;
   assign out_data  = s3_ff;

endmodule : hsvrgb_wheel

`default_nettype wire

/* rtl/core/hsvrgb_shade.sv */
// ----------------------------------------------------------------------------
// hsvrgb_shade
// two stages: mix toward white by saturation, then scale by squared value
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_shade (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire hsvrgb_pkg::mix_type in_data,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output hsvrgb_pkg::rgb_type      out_data
);
   import hsvrgb_pkg::*;

   // stage 4: saturation
   logic            vld4_ff;
   mix_type         s4_ff, s4_in;
   logic            ld4;
   logic [2:0][7:0] ch4;
   logic [2:0][7:0] res4;
   logic [8:0]      keep1;
   logic [15:0]     p4 [3];

   // stage 5: value, also the output register
   logic            vld5_ff;
   rgb_type         s5_ff, s5_in;
   logic            ld5;
   logic [2:0][7:0] ch5;
   logic [2:0][7:0] res5;
   logic [8:0]      v1;
   logic [15:0]     p5 [3];

   assign ld5      = ~vld5_ff | out_ready;
   assign ld4      = ~vld4_ff | ld5;
   assign in_ready = ld4;

   always_comb begin
      ch4   = in_data.rgb;
      keep1 = {1'b0, ~in_data.desat} + 9'd1;
      for (int j = 0; j < 3; j++) begin
         p4[j]   = 16'(ch4[j]) * 16'(keep1);
         // nonzero channels get scale plus one, then the floor is added with wrap
         res4[j] = ((ch4[j] != 8'd0) ? (p4[j][15:8] + 8'd1) : 8'd0) + in_data.desat;
      end
      s4_in = in_data;
      if (!in_data.sat_full) begin
         if (in_data.sat_zero) begin
            s4_in.rgb = {LVL_FULL, LVL_FULL, LVL_FULL};
         end else begin
            s4_in.rgb = res4;
         end
      end
   end

   always_comb begin
      ch5 = s4_ff.rgb;
      v1  = {1'b0, s4_ff.vsq} + 9'd1;
      for (int j = 0; j < 3; j++) begin
         p5[j]   = 16'(ch5[j]) * 16'(v1);
         res5[j] = (ch5[j] != 8'd0) ? (p5[j][15:8] + 8'd1) : 8'd0;
      end
      s5_in = s4_ff.rgb;
      if (!s4_ff.val_full) begin
         if (s4_ff.vsq == 8'd0) begin
            s5_in = '0;
         end else begin
            s5_in = res5;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
      end else begin
         if (ld4) vld4_ff <= in_valid;
         if (ld5) vld5_ff <= vld4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ld4) s4_ff <= s4_in;
      if (ld5) s5_ff <= s5_in;
   end

   assign out_valid = vld5_ff;
   assign out_data  = s5_ff;

   // full value passes the saturated colour straight through
   a_val_full_pass: assert property (@(posedge clock) disable iff (reset)
      (ld5 && vld4_ff && s4_ff.val_full) |=> (out_data == $past(s4_ff.rgb)))
      else $error("full value item altered by value stage");

   // value that squares to zero gives black
   a_val_zero_black: assert property (@(posedge clock) disable iff (reset)
      (ld5 && vld4_ff && !s4_ff.val_full && s4_ff.vsq == 8'd0) |=> (out_data == '0))
      else $error("zero value item not black");

endmodule : hsvrgb_shade

`default_nettype wire

/* rtl/core/hsv_to_rgb_rainbow_core.sv */
// ----------------------------------------------------------------------------
// hsv_to_rgb_rainbow_core
// 8-bit rainbow-wheel hsv to rgb conversion, if unstalled one item per clock
// ----------------------------------------------------------------------------
// usage
//  - req channel carries one hue/sat/val item, taken at a clock edge where
//    req_valid is high and req_stall is low
//  - rsp channel returns exactly one red/green/blue item per input item,
//    in order, taken where rsp_valid is high and rsp_stall is low
//  - apb port holds yellow_strong (0x0), green_halve (0x4) and
//    green_gain (0x8); write these only while no item is in flight
//  - five register stages: ramps and squares, section mix, green gain,
//    saturation mix, value scale, in that order; rsp_valid is the valid
//    bit of the value scale stage
//  - throughput is one item per cycle while rsp_stall is low, set by the
//    five-stage pipeline, one 8x9 multiplier per channel per shading stage
//  - each stage has its own valid bit and loads when empty or when the
//    next stage moves, so bubbles close up while the output is stalled;
//    req_stall rises only once every stage holds an item
//  - a stalled result stays in the output register unchanged
//  - reset (synchronous) empties the pipeline and clears the config registers
//    to zero: moderate yellow, green unchanged
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_rainbow_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // input items
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire hsvrgb_pkg::hsv_type            req_data,
   // result items
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output hsvrgb_pkg::rgb_type                 rsp_data,
   // register port
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [hsvrgb_pkg::PADDR_W-1:0] paddr,
   input  wire logic [hsvrgb_pkg::PDATA_W-1:0] pwdata,
   output logic      [hsvrgb_pkg::PDATA_W-1:0] prdata,
   output logic                                pready
);
   import hsvrgb_pkg::*;

   cfg_type cfg;
   logic    in_ready;
   logic    mid_valid;
   logic    mid_ready;
   mix_type mid_data;

   // configuration registers
   hsvrgb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // hue to wheel colour, plus squared desaturation and value terms
   hsvrgb_wheel u_wheel (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (in_ready),
      .in_data   (req_data),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_data  (mid_data)
   );

   // saturation and value shading, last stage is the output register
   hsvrgb_shade u_shade (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_data   (mid_data),
      .out_valid (rsp_valid),
      .out_ready (~rsp_stall),
      .out_data  (rsp_data)
   );

   assign req_stall = ~in_ready;

   // an empty output register never holds back the input
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output stage");

   // pipeline is empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule : hsv_to_rgb_rainbow_core

`default_nettype wire
